### rtl/apr_pkg.sv
// apr_pkg: shared constants and types for the aging page replacement block
// no dependencies; used by apr_front, apr_back and aging_page_replacement_top
package apr_pkg;

  // frame table geometry
  localparam int FRAMES       = 8;
  localparam int IDX_BITS     = 3;
  localparam int HISTORY_BITS = 8;
  localparam int PAGE_BITS    = 20;
  localparam int COUNT_BITS   = 16;

  // request queue geometry
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = 1;
  localparam int QCNT_BITS  = 2;

  localparam logic [HISTORY_BITS-1:0] HIST_TOP = {1'b1, {(HISTORY_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX = {COUNT_BITS{1'b1}};

  // request handed from the front queue to the back end
  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
  } apr_req_t;

endpackage

### rtl/aging_page_replacement_top.sv
// aging_page_replacement_top: aging page replacement over a small frame table
// depends on apr_pkg, apr_front, apr_back
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  request | req_valid, req_stall | page_number
//  result  | rsp_valid, rsp_stall | hit, frame_index, evicted_valid,
//          |                      | evicted_page, fault_total
//
// one request per cycle is sustained while the result is not stalled; a request
// passes through the queue, then the frame table update, into the result register
// the frame table compares, ages and picks a victim for all frames combinationally
// rst is synchronous and clears the queue, valid marks, histories and counter
// a stalled result holds; the two-entry queue keeps taking requests until full
module aging_page_replacement_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [apr_pkg::PAGE_BITS-1:0]  page_number,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           hit,
  output logic [apr_pkg::IDX_BITS-1:0]   frame_index,
  output logic                           evicted_valid,
  output logic [apr_pkg::PAGE_BITS-1:0]  evicted_page,
  output logic [apr_pkg::COUNT_BITS-1:0] fault_total
);

  apr_pkg::apr_req_t req;
  logic              take;

  // request queue
  apr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .page_number (page_number),
    .req         (req),
    .take        (take)
  );

  // frame table and result register
  apr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .take          (take),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule

### rtl/apr_front.sv
// apr_front: accepts page requests and holds them in a short queue
// depends on apr_pkg
module apr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [apr_pkg::PAGE_BITS-1:0] page_number,
  output apr_pkg::apr_req_t             req,
  input  logic                          take
);

  logic [apr_pkg::PAGE_BITS-1:0] q_mem [apr_pkg::QDEPTH];
  logic [apr_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [apr_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [apr_pkg::QCNT_BITS-1:0] count;
  logic                          push;
  logic                          pop;

  // handshake on both sides of the queue
  assign req_stall = (count == apr_pkg::QCNT_BITS'(apr_pkg::QDEPTH));
  assign push      = req_valid && !req_stall;
  assign req.valid = (count != '0);
  assign req.page  = q_mem[rd_ptr];
  assign pop       = req.valid && take;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= page_number;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/apr_back.sv
// apr_back: frame table, aging, hit search, victim choice and result register
// depends on apr_pkg
module apr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  apr_pkg::apr_req_t              req,
  output logic                           take,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           hit,
  output logic [apr_pkg::IDX_BITS-1:0]   frame_index,
  output logic                           evicted_valid,
  output logic [apr_pkg::PAGE_BITS-1:0]  evicted_page,
  output logic [apr_pkg::COUNT_BITS-1:0] fault_total
);

  logic [apr_pkg::PAGE_BITS-1:0]    frame_page    [apr_pkg::FRAMES];
  logic [apr_pkg::FRAMES-1:0]       frame_valid;
  logic [apr_pkg::HISTORY_BITS-1:0] frame_history [apr_pkg::FRAMES];
  logic [apr_pkg::COUNT_BITS-1:0]   fault_counter;

  logic [apr_pkg::HISTORY_BITS-1:0] aged [apr_pkg::FRAMES];
  logic                             found;
  logic [apr_pkg::IDX_BITS-1:0]     hit_idx;
  logic                             have_empty;
  logic [apr_pkg::IDX_BITS-1:0]     empty_idx;
  logic [apr_pkg::IDX_BITS-1:0]     min_idx;
  logic [apr_pkg::HISTORY_BITS-1:0] min_hist;
  logic [apr_pkg::IDX_BITS-1:0]     slot;
  logic                             ev_valid;
  logic [apr_pkg::COUNT_BITS-1:0]   fault_counter_next;

  // take a request when the result register is free or draining
  assign take = req.valid && (!rsp_valid || !rsp_stall);

  // age every history and search for the page, lowest index first
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int f = apr_pkg::FRAMES - 1; f >= 0; f--) begin
      aged[f] = frame_history[f] >> 1;
      if (frame_valid[f] && (frame_page[f] == req.page)) begin
        found   = 1'b1;
        hit_idx = apr_pkg::IDX_BITS'(f);
      end
    end
  end

  // victim: first empty frame, else smallest aged history
  always_comb begin
    have_empty = 1'b0;
    empty_idx  = '0;
    for (int f = apr_pkg::FRAMES - 1; f >= 0; f--) begin
      if (!frame_valid[f]) begin
        have_empty = 1'b1;
        empty_idx  = apr_pkg::IDX_BITS'(f);
      end
    end
    min_idx  = '0;
    min_hist = aged[0];
    for (int f = 1; f < apr_pkg::FRAMES; f++) begin
      if (aged[f] < min_hist) begin
        min_idx  = apr_pkg::IDX_BITS'(f);
        min_hist = aged[f];
      end
    end
  end

  // frame used and eviction status
  always_comb begin
    if (found) begin
      slot = hit_idx;
    end else if (have_empty) begin
      slot = empty_idx;
    end else begin
      slot = min_idx;
    end
    ev_valid = !found && !have_empty;
    if (!found && (fault_counter != apr_pkg::COUNT_MAX)) begin
      fault_counter_next = fault_counter + 1'b1;
    end else begin
      fault_counter_next = fault_counter;
    end
  end

  // page numbers are written only on a fault
  always_ff @(posedge clk) begin
    if (take && !found) begin
      frame_page[slot] <= req.page;
    end
  end

  // valid marks, histories and fault counter
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      fault_counter <= '0;
      for (int f = 0; f < apr_pkg::FRAMES; f++) begin
        frame_history[f] <= '0;
      end
    end else if (take) begin
      fault_counter     <= fault_counter_next;
      frame_valid[slot] <= 1'b1;
      for (int f = 0; f < apr_pkg::FRAMES; f++) begin
        if (apr_pkg::IDX_BITS'(f) != slot) begin
          frame_history[f] <= aged[f];
        end else if (found) begin
          frame_history[f] <= aged[f] | apr_pkg::HIST_TOP;
        end else begin
          frame_history[f] <= apr_pkg::HIST_TOP;
        end
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      hit           <= found;
      frame_index   <= slot;
      evicted_valid <= ev_valid;
      evicted_page  <= ev_valid ? frame_page[slot] : '0;
      fault_total   <= fault_counter_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

### dv/aging_page_replacement_top_tb.sv
// aging_page_replacement_top_tb: self-checking bench for the aging page replacement block
// depends on apr_pkg and aging_page_replacement_top; a local predictor tracks the frame table
`timescale 1ns / 1ps

module aging_page_replacement_top_tb;

  typedef struct packed {
    logic                           hit;
    logic [apr_pkg::IDX_BITS-1:0]   frame_index;
    logic                           evicted_valid;
    logic [apr_pkg::PAGE_BITS-1:0]  evicted_page;
    logic [apr_pkg::COUNT_BITS-1:0] fault_total;
  } lookup_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_SPARSE, RX_HEAVY} rx_mode_e;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  logic [apr_pkg::PAGE_BITS-1:0]  page_number = '0;
  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  logic                           hit;
  logic [apr_pkg::IDX_BITS-1:0]   frame_index;
  logic                           evicted_valid;
  logic [apr_pkg::PAGE_BITS-1:0]  evicted_page;
  logic [apr_pkg::COUNT_BITS-1:0] fault_total;

  // predicted frame table
  logic [apr_pkg::PAGE_BITS-1:0]    resident_page [apr_pkg::FRAMES];
  bit                               resident_valid [apr_pkg::FRAMES];
  logic [apr_pkg::HISTORY_BITS-1:0] resident_hist [apr_pkg::FRAMES];
  logic [apr_pkg::COUNT_BITS-1:0]   fault_tally;

  lookup_result_t pending_results [$];
  int             mismatches = 0;
  int             burst_left = 0;
  rx_mode_e       rx_mode = RX_FREE;
  int             rx_left = 0;

  aging_page_replacement_top dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .page_number   (page_number),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // one line per mismatch, printing capped so a broken build stays readable
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // age every frame, then look up the page and pick a victim on a miss
  function automatic lookup_result_t predict_access(input logic [apr_pkg::PAGE_BITS-1:0] pg);
    lookup_result_t                   res;
    int                               slot;
    bit                               found;
    logic [apr_pkg::HISTORY_BITS-1:0] best;
    res   = '0;
    found = 1'b0;
    slot  = -1;
    for (int f = 0; f < apr_pkg::FRAMES; f++)
      resident_hist[f] = resident_hist[f] >> 1;
    for (int f = 0; f < apr_pkg::FRAMES; f++) begin
      if (!found && resident_valid[f] && resident_page[f] == pg) begin
        found = 1'b1;
        slot  = f;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      resident_hist[slot] = resident_hist[slot] | apr_pkg::HIST_TOP;
    end else begin
      // first empty frame, else smallest aged history with lowest index on ties
      for (int f = 0; f < apr_pkg::FRAMES; f++) begin
        if (slot < 0 && !resident_valid[f])
          slot = f;
      end
      if (slot < 0) begin
        slot = 0;
        best = resident_hist[0];
        for (int f = 1; f < apr_pkg::FRAMES; f++) begin
          if (resident_hist[f] < best) begin
            slot = f;
            best = resident_hist[f];
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = resident_page[slot];
      end
      resident_valid[slot] = 1'b1;
      resident_page[slot]  = pg;
      resident_hist[slot]  = apr_pkg::HIST_TOP;
      if (fault_tally != apr_pkg::COUNT_MAX)
        fault_tally = fault_tally + 1'b1;
    end
    res.frame_index = slot[apr_pkg::IDX_BITS-1:0];
    res.fault_total = fault_tally;
    return res;
  endfunction

  // one request transfer, with bursts and gaps on the sending side
  task automatic request_page(input logic [apr_pkg::PAGE_BITS-1:0] pg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid   <= 1'b1;
    page_number <= pg;
    do begin
      @(posedge clk);
    end while (req_stall);
    burst_left--;
    pending_results.push_back(predict_access(pg));
  endtask

  // receiver stall pattern, switching at random among free, sparse and heavy stalling
  always @(posedge clk) begin : stall_pattern
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(8, 64);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:   rsp_stall <= 1'b0;
      RX_SPARSE: rsp_stall <= ($urandom_range(0, 7) == 0);
      default:   rsp_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", fault_total, 0);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit)
          report_mismatch("hit", hit, want.hit);
        if (frame_index !== want.frame_index)
          report_mismatch("frame_index", frame_index, want.frame_index);
        if (evicted_valid !== want.evicted_valid)
          report_mismatch("evicted_valid", evicted_valid, want.evicted_valid);
        if (evicted_page !== want.evicted_page)
          report_mismatch("evicted_page", evicted_page, want.evicted_page);
        if (fault_total !== want.fault_total)
          report_mismatch("fault_total", fault_total, want.fault_total);
      end
    end
  end

  // faults into empty frames, extreme page numbers among them
  task automatic test_fill_empty_frames();
    request_page(20'h00000);
    request_page(20'hFFFFF);
    request_page(20'h80000);
    request_page(20'h7FFFF);
    request_page(20'h55555);
    request_page(20'hAAAAA);
    request_page(20'h00001);
    request_page(20'hFFFFE);
  endtask

  // hits on resident pages, including a repeat of the same page
  task automatic test_hits();
    request_page(20'h00000);
    request_page(20'hFFFFF);
    request_page(20'hFFFFF);
    request_page(20'h55555);
  endtask

  // smallest aged history loses; equal histories fall to the lowest index
  task automatic test_victim_choice();
    request_page(20'h12345);
    request_page(20'h0F0F0);
    for (int i = 0; i < 9; i++)
      request_page(20'h55555);
    request_page(20'h3C3C3);
    request_page(20'hC3C3C);
  endtask

  // locality-heavy traffic with fresh pages and edge values mixed in
  task automatic test_random_traffic(input int n);
    logic [apr_pkg::PAGE_BITS-1:0] hot_pages [16];
    int                            hot_count;
    int                            roll;
    int                            bitpos;
    logic [apr_pkg::PAGE_BITS-1:0] pg;
    hot_count = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        hot_count = $urandom_range(4, 14);
        for (int k = 0; k < 16; k++)
          hot_pages[k] = apr_pkg::PAGE_BITS'($urandom_range(0, 20'hFFFFF));
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        pg = hot_pages[4'($urandom_range(0, hot_count - 1))];
      end else if (roll < 90) begin
        pg = apr_pkg::PAGE_BITS'($urandom_range(0, 20'hFFFFF));
      end else begin
        bitpos = $urandom_range(0, apr_pkg::PAGE_BITS - 1);
        case ($urandom_range(0, 3))
          0:       pg = '0;
          1:       pg = '1;
          2:       pg = 20'h1 << bitpos;
          default: pg = ~(20'h1 << bitpos);
        endcase
      end
      request_page(pg);
    end
  endtask

  initial begin : main_sequence
    int waited;
    for (int f = 0; f < apr_pkg::FRAMES; f++) begin
      resident_page[f]  = '0;
      resident_valid[f] = 1'b0;
      resident_hist[f]  = '0;
    end
    fault_tally = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_empty_frames();
    test_hits();
    test_victim_choice();
    test_random_traffic(475);
    req_valid <= 1'b0;

    // drain outstanding results, then allow for the pipeline depth
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### aging_page_replacement_top.f
rtl/apr_pkg.sv
rtl/apr_front.sv
rtl/apr_back.sv
rtl/aging_page_replacement_top.sv
dv/aging_page_replacement_top_tb.sv
